@@ design/i8i4qd_pkg.sv @@
package i8i4qd_pkg;

  typedef enum logic [2:0] {
    FUNC_QUANT8  = 3'd0,
    FUNC_QUANT4  = 3'd1,
    FUNC_DEQ8    = 3'd2,
    FUNC_DEQ4    = 3'd3,
    FUNC_REPACK  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    CFG_SCALE       = 2'd0,
    CFG_INV_SCALE   = 2'd1,
    CFG_ZERO_OFFSET = 2'd2
  } cfg_idx_t;

  localparam logic [31:0]        SCALE_RST     = 32'h0001_0000;
  localparam logic [31:0]        INV_SCALE_RST = 32'h0001_0000;
  localparam logic signed [15:0] ZERO_OFF_RST  = 16'sd0;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } deq_t;

  // |diff| * inv, rounded half away from zero, clamped to int8 or int4
  function automatic logic [7:0] quant(logic signed [32:0] diff, logic [31:0] inv,
                                       logic is4);
    logic [32:0] negd;
    logic [31:0] mag;
    logic [63:0] prod;
    logic [8:0]  q;
    logic [8:0]  lim_p;
    logic [8:0]  lim_n;
    logic [8:0]  t;
    logic [7:0]  r;
    negd  = 33'd0 - diff;
    mag   = diff[32] ? negd[31:0] : diff[31:0];
    prod  = {32'd0, mag} * {32'd0, inv};
    q     = (|prod[63:40]) ? 9'd256 : ({1'b0, prod[39:32]} + {8'd0, prod[31]});
    lim_p = is4 ? 9'd7 : 9'd127;
    lim_n = is4 ? 9'd8 : 9'd128;
    if (diff[32]) begin
      t = (q > lim_n) ? lim_n : q;
      t = 9'd0 - t;
      r = t[7:0];
    end else begin
      t = (q > lim_p) ? lim_p : q;
      r = t[7:0];
    end
    return r;
  endfunction

  // code * scale + offset, clipped to 32 bits
  function automatic deq_t dequant(logic signed [7:0] code, logic [31:0] scale,
                                   logic signed [15:0] zoff);
    logic signed [40:0] prod;
    logic signed [41:0] off;
    logic signed [41:0] sum;
    deq_t               r;
    prod = $signed({{33{code[7]}}, code}) * $signed({9'd0, scale});
    off  = $signed({{10{zoff[15]}}, zoff, 16'd0});
    sum  = $signed({prod[40], prod}) + off;
    r.sat = !((&sum[41:31]) || !(|sum[41:31]));
    if (r.sat) begin
      r.val = sum[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r.val = sum[31:0];
    end
    return r;
  endfunction

  // int8 halved toward zero, clamped to int4
  function automatic logic [3:0] halve(logic signed [7:0] code);
    logic signed [8:0] h;
    logic [3:0]        r;
    h = ($signed({code[7], code}) + $signed({8'd0, code[7]})) >>> 1;
    if (h < -9'sd8) begin
      r = 4'h8;
    end else if (h > 9'sd7) begin
      r = 4'h7;
    end else begin
      r = h[3:0];
    end
    return r;
  endfunction

endpackage

@@ design/int8_int4_quantize_dequantize.sv @@
// Affine int8/int4 quantize-dequantize unit. A request is taken whenever start is high
// and busy is low; busy is high only while in reset, so one request can be issued every
// cycle. The result appears on the out_ ports in the cycle in which out_valid is high,
// after the request has passed the input register and then the 32x32 multiplier into the
// result register. The result is shown for that single cycle and cannot be held off, so
// the receiver must take it. Register writes (cfg_valid with cfg_ready) should be made
// only when no request is in flight.
module int8_int4_quantize_dequantize (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_value_a,
  input  logic signed [31:0] in_value_b,
  input  logic signed [7:0]  in_code_a,
  input  logic signed [7:0]  in_code_b,
  input  logic [7:0]         in_packed_in,
  output logic               out_valid,
  output logic signed [7:0]  out_code_out,
  output logic [7:0]         out_packed_out,
  output logic signed [31:0] out_value_out_a,
  output logic signed [31:0] out_value_out_b,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import i8i4qd_pkg::*;

  logic               busy_r;
  logic [31:0]        scale_r;
  logic [31:0]        inv_scale_r;
  logic signed [15:0] zoff_r;

  logic               in_vld_r;
  logic [2:0]         func_r;
  logic signed [31:0] va_r;
  logic signed [31:0] vb_r;
  logic signed [7:0]  ca_r;
  logic signed [7:0]  cb_r;
  logic [7:0]         pk_r;

  logic               out_vld_r;
  logic [7:0]         code_r,   code_nxt;
  logic [7:0]         packed_r, packed_nxt;
  logic [31:0]        val_a_r,  val_a_nxt;
  logic [31:0]        val_b_r,  val_b_nxt;
  logic               sat_r,    sat_nxt;

  logic signed [32:0] diff_a;
  logic signed [32:0] diff_b;
  logic [7:0]         q_a;
  logic [7:0]         q_b;
  logic signed [7:0]  deq_code_a;
  deq_t               deq_a;
  deq_t               deq_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCALE_RST;
      inv_scale_r <= INV_SCALE_RST;
      zoff_r      <= ZERO_OFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCALE:       scale_r     <= cfg_data;
        CFG_INV_SCALE:   inv_scale_r <= cfg_data;
        CFG_ZERO_OFFSET: zoff_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      func_r <= in_func;
      va_r   <= in_value_a;
      vb_r   <= in_value_b;
      ca_r   <= in_code_a;
      cb_r   <= in_code_b;
      pk_r   <= in_packed_in;
    end
  end

  // on the quantize side, the offset only applies to int8 quantize
  assign diff_a = $signed({va_r[31], va_r}) -
                  ((func_r == FUNC_QUANT8) ? $signed({zoff_r[15], zoff_r, 16'd0}) : 33'sd0);
  assign diff_b = $signed({vb_r[31], vb_r});

  assign q_a = quant(diff_a, inv_scale_r, func_r != FUNC_QUANT8);
  assign q_b = quant(diff_b, inv_scale_r, 1'b1);

  assign deq_code_a = (func_r == FUNC_DEQ8) ? ca_r : {{4{pk_r[3]}}, pk_r[3:0]};
  assign deq_a      = dequant(deq_code_a, scale_r, zoff_r);
  assign deq_b      = dequant({{4{pk_r[7]}}, pk_r[7:4]}, scale_r, zoff_r);

  always_comb begin
    code_nxt   = 8'd0;
    packed_nxt = 8'd0;
    val_a_nxt  = 32'd0;
    val_b_nxt  = 32'd0;
    sat_nxt    = 1'b0;
    case (func_r)
      FUNC_QUANT8: begin
        code_nxt = q_a;
      end
      FUNC_QUANT4: begin
        packed_nxt = {q_b[3:0], q_a[3:0]};
      end
      FUNC_DEQ8: begin
        val_a_nxt = deq_a.val;
        sat_nxt   = deq_a.sat;
      end
      FUNC_DEQ4: begin
        val_a_nxt = deq_a.val;
        val_b_nxt = deq_b.val;
        sat_nxt   = deq_a.sat || deq_b.sat;
      end
      FUNC_REPACK: begin
        packed_nxt = {halve(cb_r), halve(ca_r)};
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      code_r   <= code_nxt;
      packed_r <= packed_nxt;
      val_a_r  <= val_a_nxt;
      val_b_r  <= val_b_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_code_out    = code_r;
  assign out_packed_out  = packed_r;
  assign out_value_out_a = val_a_r;
  assign out_value_out_b = val_b_r;
  assign out_saturated   = sat_r;

endmodule

@@ design/i8i4qd_chk.sv @@
module i8i4qd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [2:0]         in_func,
  input logic signed [31:0] in_value_a,
  input logic signed [31:0] in_value_b,
  input logic signed [7:0]  in_code_a,
  input logic signed [7:0]  in_code_b,
  input logic [7:0]         in_packed_in,
  input logic               out_valid,
  input logic signed [7:0]  out_code_out,
  input logic [7:0]         out_packed_out,
  input logic signed [31:0] out_value_out_a,
  input logic signed [31:0] out_value_out_b,
  input logic               out_saturated,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [1:0]         cfg_index,
  input logic [31:0]        cfg_data
);
  import i8i4qd_pkg::*;

  // every request that is not cut off by reset gives a result
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) ##1 rst_n |=> out_valid)
    else $error("request produced no result");

  a_res_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without request");

  a_code_func: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_code_out != 8'sd0) |-> $past(in_func, 2) == FUNC_QUANT8)
    else $error("int8 code on wrong operation");

  a_sat_func: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      ($past(in_func, 2) == FUNC_DEQ8 || $past(in_func, 2) == FUNC_DEQ4))
    else $error("saturation flag on wrong operation");

  a_pack_func: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_packed_out != 8'd0) |->
      ($past(in_func, 2) == FUNC_QUANT4 || $past(in_func, 2) == FUNC_REPACK))
    else $error("packed byte on wrong operation");

endmodule

bind int8_int4_quantize_dequantize i8i4qd_chk u_i8i4qd_chk (.*);

@@ tb/sv/quant_dequant_checker.sv @@
module quant_dequant_checker
  import i8i4qd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_value_a,
  input  logic signed [31:0] in_value_b,
  input  logic signed [7:0]  in_code_a,
  input  logic signed [7:0]  in_code_b,
  input  logic [7:0]         in_packed_in,
  input  logic               out_valid,
  input  logic signed [7:0]  out_code_out,
  input  logic [7:0]         out_packed_out,
  input  logic signed [31:0] out_value_out_a,
  input  logic signed [31:0] out_value_out_b,
  input  logic               out_saturated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 mismatches,
  output int unsigned        in_flight
);

  typedef struct {
    logic [7:0]  code;
    logic [7:0]  pack_byte;
    logic [31:0] val_a;
    logic [31:0] val_b;
    logic        sat;
  } qd_result_t;

  logic [31:0]        scale_r;
  logic [31:0]        inv_scale_r;
  logic signed [15:0] zoff_r;
  qd_result_t         exp_q[$];
  qd_result_t         head;

  initial begin
    mismatches = 0;
    in_flight  = 0;
  end

  // |diff| * inv in Q32.32, rounded half away from zero, then clamped
  function automatic logic [7:0] round_clamp(longint diff, logic [31:0] inv, longint lo,
                                             longint hi);
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    longint      r;
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = mag * {32'd0, inv};
    q    = (prod >= (64'd256 << 32)) ? 64'd256 : ((prod + 64'h8000_0000) >> 32);
    r    = (diff < 0) ? -longint'(q) : longint'(q);
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r[7:0];
  endfunction

  // code * scale + offset; bit 32 flags clipping to the 32-bit range
  function automatic logic [32:0] deq_clip(longint code);
    longint v;
    v = code * longint'({32'd0, scale_r}) + longint'(zoff_r) * 65536;
    if (v > 64'sh7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    if (v < -64'sh8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [3:0] half_nibble(logic signed [7:0] c);
    int h;
    h = int'(c) / 2;
    if (h < -8) h = -8;
    else if (h > 7) h = 7;
    return 4'(h);
  endfunction

  function automatic qd_result_t predict_result(logic [2:0] f, logic signed [31:0] va,
                                                logic signed [31:0] vb,
                                                logic signed [7:0] ca,
                                                logic signed [7:0] cb,
                                                logic [7:0] pin);
    qd_result_t  r;
    logic [32:0] da;
    logic [32:0] db;
    logic [7:0]  qa;
    logic [7:0]  qb;
    r = '{code: 8'd0, pack_byte: 8'd0, val_a: 32'd0, val_b: 32'd0, sat: 1'b0};
    case (f)
      FUNC_QUANT8: begin
        r.code = round_clamp(longint'(va) - longint'(zoff_r) * 65536, inv_scale_r,
                             -128, 127);
      end
      FUNC_QUANT4: begin
        qa = round_clamp(longint'(va), inv_scale_r, -8, 7);
        qb = round_clamp(longint'(vb), inv_scale_r, -8, 7);
        r.pack_byte = {qb[3:0], qa[3:0]};
      end
      FUNC_DEQ8: begin
        da      = deq_clip(longint'(ca));
        r.val_a = da[31:0];
        r.sat   = da[32];
      end
      FUNC_DEQ4: begin
        da      = deq_clip(longint'($signed(pin[3:0])));
        db      = deq_clip(longint'($signed(pin[7:4])));
        r.val_a = da[31:0];
        r.val_b = db[31:0];
        r.sat   = da[32] | db[32];
      end
      FUNC_REPACK: begin
        r.pack_byte = {half_nibble(cb), half_nibble(ca)};
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scale_r     = SCALE_RST;
      inv_scale_r = INV_SCALE_RST;
      zoff_r      = ZERO_OFF_RST;
      exp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCALE:       scale_r     = cfg_data;
          CFG_INV_SCALE:   inv_scale_r = cfg_data;
          CFG_ZERO_OFFSET: zoff_r      = cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (out_valid) begin
        if (exp_q.size() == 0) begin
          report_mismatch("result with no request pending", 32'(out_code_out), 32'd0);
        end else begin
          head = exp_q.pop_front();
          if (out_code_out !== head.code)
            report_mismatch("code_out", 32'(out_code_out), 32'(head.code));
          if (out_packed_out !== head.pack_byte)
            report_mismatch("packed_out", 32'(out_packed_out), 32'(head.pack_byte));
          if (out_value_out_a !== head.val_a)
            report_mismatch("value_out_a", out_value_out_a, head.val_a);
          if (out_value_out_b !== head.val_b)
            report_mismatch("value_out_b", out_value_out_b, head.val_b);
          if (out_saturated !== head.sat)
            report_mismatch("saturated", 32'(out_saturated), 32'(head.sat));
        end
      end
      if (start && !busy) begin
        exp_q.insert(exp_q.size(), predict_result(in_func, in_value_a, in_value_b,
                                                  in_code_a, in_code_b, in_packed_in));
      end
    end
    in_flight <= exp_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import i8i4qd_pkg::*;

  localparam int CYCLE_LIMIT     = 400_000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int FUNC_CODE_MAX   = 7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_func = '0;
  logic signed [31:0] in_value_a = '0;
  logic signed [31:0] in_value_b = '0;
  logic signed [7:0]  in_code_a = '0;
  logic signed [7:0]  in_code_b = '0;
  logic [7:0]         in_packed_in = '0;
  logic               out_valid;
  logic signed [7:0]  out_code_out;
  logic [7:0]         out_packed_out;
  logic signed [31:0] out_value_out_a;
  logic signed [31:0] out_value_out_b;
  logic               out_saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 mismatches;
  int unsigned        in_flight;
  int                 cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int8_int4_quantize_dequantize u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_value_a     (in_value_a),
    .in_value_b     (in_value_b),
    .in_code_a      (in_code_a),
    .in_code_b      (in_code_b),
    .in_packed_in   (in_packed_in),
    .out_valid      (out_valid),
    .out_code_out   (out_code_out),
    .out_packed_out (out_packed_out),
    .out_value_out_a(out_value_out_a),
    .out_value_out_b(out_value_out_b),
    .out_saturated  (out_saturated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  quant_dequant_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_value_a     (in_value_a),
    .in_value_b     (in_value_b),
    .in_code_a      (in_code_a),
    .in_code_b      (in_code_b),
    .in_packed_in   (in_packed_in),
    .out_valid      (out_valid),
    .out_code_out   (out_code_out),
    .out_packed_out (out_packed_out),
    .out_value_out_a(out_value_out_a),
    .out_value_out_b(out_value_out_b),
    .out_saturated  (out_saturated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .in_flight      (in_flight)
  );

  task automatic send_req(logic [2:0] f, logic [31:0] va, logic [31:0] vb, logic [7:0] ca,
                          logic [7:0] cb, logic [7:0] pin);
    in_func      <= f;
    in_value_a   <= va;
    in_value_b   <= vb;
    in_code_a    <= ca;
    in_code_b    <= cb;
    in_packed_in <= pin;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // drop start, wait for every request to come back, then cover the pipeline
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic logic [31:0] pick_value(logic signed [15:0] zo);
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      2:       return {zo, 16'h0} + 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      default: return 32'($urandom_range(0, 1 << 27)) - 32'(1 << 26);
    endcase
  endfunction

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [31:0]        sc;
    logic [31:0]        iv;
    logic signed [15:0] zo;
    logic [2:0]         f;
    int                 r;
    int                 gap;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: unit scale, no offset
    send_req(FUNC_QUANT8, 32'h0000_0000, '0, '0, '0, '0);
    send_req(FUNC_QUANT8, 32'h0000_8000, '0, '0, '0, '0);
    send_req(FUNC_QUANT8, 32'hFFFF_8000, '0, '0, '0, '0);
    send_req(FUNC_QUANT8, 32'h0000_7FFF, '0, '0, '0, '0);
    send_req(FUNC_QUANT8, 32'h007F_0000, '0, '0, '0, '0);
    send_req(FUNC_QUANT8, 32'h0080_0000, '0, '0, '0, '0);
    send_req(FUNC_QUANT8, 32'hFF80_0000, '0, '0, '0, '0);
    send_req(FUNC_QUANT8, 32'hFF7F_0000, '0, '0, '0, '0);
    send_req(FUNC_QUANT8, 32'h7FFF_FFFF, '0, '0, '0, '0);
    send_req(FUNC_QUANT8, 32'h8000_0000, '0, '0, '0, '0);
    send_req(FUNC_QUANT4, 32'h0007_0000, 32'hFFF8_0000, '0, '0, '0);
    send_req(FUNC_QUANT4, 32'h0008_0000, 32'hFFF7_0000, '0, '0, '0);
    send_req(FUNC_QUANT4, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0);
    send_req(FUNC_QUANT4, 32'h0001_8000, 32'hFFFE_8000, '0, '0, '0);
    send_req(FUNC_DEQ8, '0, '0, 8'h7F, '0, '0);
    send_req(FUNC_DEQ8, '0, '0, 8'h80, '0, '0);
    send_req(FUNC_DEQ8, '0, '0, 8'h00, '0, '0);
    send_req(FUNC_DEQ4, '0, '0, '0, '0, 8'h87);
    send_req(FUNC_DEQ4, '0, '0, '0, '0, 8'h78);
    send_req(FUNC_DEQ4, '0, '0, '0, '0, 8'hFF);
    send_req(FUNC_REPACK, '0, '0, 8'h7F, 8'h80, '0);
    send_req(FUNC_REPACK, '0, '0, 8'hFF, 8'h01, '0);
    send_req(FUNC_REPACK, '0, '0, 8'hEF, 8'h11, '0);
    send_req(FUNC_REPACK, '0, '0, 8'h0F, 8'hF1, '0);
    for (int k = int'(FUNC_REPACK) + 1; k <= FUNC_CODE_MAX; k++) begin
      send_req(3'(k), $urandom, $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
    end

    for (int p = 1; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        1: begin
          sc = 32'h0001_0000; iv = 32'h0001_0000; zo = 16'sd0;
        end
        2: begin
          sc = 32'd1; iv = 32'd1; zo = -16'sd32768;
        end
        3: begin
          sc = 32'hFFFF_FFFF; iv = 32'hFFFF_FFFF; zo = 16'sd32767;
        end
        4: begin
          sc = 32'd0; iv = 32'd0; zo = 16'sd0;
        end
        5: begin
          sc = $urandom_range(1 << 12, 1 << 20);
          iv = $urandom_range(1 << 12, 1 << 20);
          zo = 16'($urandom_range(0, 512)) - 16'sd256;
        end
        6: begin
          sc = $urandom; iv = $urandom; zo = 16'($urandom);
        end
        default: begin
          sc = $urandom_range(1 << 14, 1 << 18);
          iv = $urandom_range(1 << 10, 1 << 16);
          zo = 16'($urandom);
        end
      endcase
      write_reg(CFG_SCALE, sc);
      write_reg(CFG_INV_SCALE, iv);
      write_reg(CFG_ZERO_OFFSET, 32'(zo));
      cfg_valid <= 1'b0;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 19);
        f = (r == 19) ? 3'($urandom_range(int'(FUNC_REPACK) + 1, FUNC_CODE_MAX)) : 3'(r % 5);
        send_req(f, pick_value(zo), pick_value(zo), 8'($urandom), 8'($urandom),
                 8'($urandom));
        r = $urandom_range(0, 99);
        if (n >= 60 && n < 110) gap = 0;
        else if (r < 55) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) idle_cycles(gap);
        // hold off until the pipeline has drained
        if (n == 150) settle();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
